>>> design/positional_list_engine_defines.svh
// ---------------------------------------------------------------------------
// positional list engine assertion macros
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define PLE_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define PLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ple_pkg.sv
// ---------------------------------------------------------------------------
// ple_pkg
// shared widths, codes and the operation record of the positional list engine
// ---------------------------------------------------------------------------
package ple_pkg;

  localparam int MODE_W = 3;
  localparam int ITEM_W = 32;
  localparam int POS_W  = 8;
  localparam int LEN_W  = 6;

  localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_POS   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_FRONT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_BACK  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DEL_POS   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd6;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NOP  = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2,
    OP_DUMP = 2'd3
  } op_kind_e;

  typedef enum logic [1:0] {
    LOC_FRONT = 2'd0,
    LOC_BACK  = 2'd1,
    LOC_POS   = 2'd2
  } loc_e;

  typedef struct packed {
    op_kind_e                 kind;
    loc_e                     loc;
    logic                     pos_zero;
    logic [POS_W-1:0]         idx;
    logic signed [ITEM_W-1:0] value;
  } op_t;

endpackage

>>> design/ple_front.sv
// ---------------------------------------------------------------------------
// ple_front
// decodes an incoming transaction into an operation record for the queue
// ---------------------------------------------------------------------------
module ple_front (
  input  logic [ple_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [ple_pkg::ITEM_W-1:0] item_in_i,
  input  logic [ple_pkg::POS_W-1:0]         position_i,
  output ple_pkg::op_t                      op_o
);
  import ple_pkg::*;

  always_comb begin
    op_o.value    = item_in_i;
    // positions are 1-based, cells 0-based
    op_o.pos_zero = (position_i == '0);
    op_o.idx      = position_i - 1'b1;
    op_o.kind     = OP_NOP;
    op_o.loc      = LOC_FRONT;
    case (mode_i)
      MODE_INS_FRONT: begin
        op_o.kind = OP_INS;
        op_o.loc  = LOC_FRONT;
      end
      MODE_INS_BACK: begin
        op_o.kind = OP_INS;
        op_o.loc  = LOC_BACK;
      end
      MODE_INS_POS: begin
        op_o.kind = OP_INS;
        op_o.loc  = LOC_POS;
      end
      MODE_DEL_FRONT: begin
        op_o.kind = OP_DEL;
        op_o.loc  = LOC_FRONT;
      end
      MODE_DEL_BACK: begin
        op_o.kind = OP_DEL;
        op_o.loc  = LOC_BACK;
      end
      MODE_DEL_POS: begin
        op_o.kind = OP_DEL;
        op_o.loc  = LOC_POS;
      end
      MODE_DUMP: begin
        op_o.kind = OP_DUMP;
      end
      default: begin
        op_o.kind = OP_NOP;
      end
    endcase
  end

endmodule

>>> design/ple_queue.sv
// ---------------------------------------------------------------------------
// ple_queue
// two-entry queue of decoded operations between front and back
// ---------------------------------------------------------------------------
module ple_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  ple_pkg::op_t op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output ple_pkg::op_t op_o
);
  import ple_pkg::*;

  op_t        slots_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign op_o    = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 2'd1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

>>> design/ple_back.sv
// ---------------------------------------------------------------------------
// ple_back
// shifting cell array that carries out list operations and drives results
// ---------------------------------------------------------------------------
module ple_back #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  ple_pkg::op_t                      q_op_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ple_pkg::status_e                  status_o,
  output logic [ple_pkg::LEN_W-1:0]         length_o,
  output logic signed [ple_pkg::ITEM_W-1:0] item_out_o,
  output logic                              is_last_o
);
  import ple_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_OP   = 2'b01,
    S_DUMP = 2'b10
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  state_e                   state_q, state_d;
  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            rem_q, rem_d;
  logic signed [ITEM_W-1:0] cells_q [CAPACITY];
  logic signed [ITEM_W-1:0] cells_d [CAPACITY];
  cell_op_e                 cell_op;
  logic [POS_W-1:0]         eidx;
  logic [POS_W-1:0]         count_pos;
  logic [POS_W-1:0]         last_pos;
  logic                     out_ready;
  logic                     out_load;
  status_e                  res_status;
  logic signed [ITEM_W-1:0] res_item;
  logic                     res_last;

  logic                     out_valid_q;
  status_e                  status_q;
  logic [LEN_W-1:0]         length_q;
  logic signed [ITEM_W-1:0] item_q;
  logic                     last_q;

  assign count_pos = POS_W'(count_q);
  assign last_pos  = count_pos - 1'b1;
  assign out_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rem_d      = rem_q;
    cell_op    = CELL_HOLD;
    eidx       = '0;
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    res_status = ST_OK;
    res_item   = '0;
    res_last   = 1'b1;
    case (state_q)
      S_OP: begin
        if (q_valid_i && out_ready) begin
          q_pop_o  = 1'b1;
          out_load = 1'b1;
          case (q_op_i.kind)
            OP_INS: begin
              case (q_op_i.loc)
                LOC_FRONT: eidx = '0;
                LOC_BACK:  eidx = count_pos;
                default:   eidx = q_op_i.idx;
              endcase
              if (q_op_i.loc == LOC_POS && (q_op_i.pos_zero || q_op_i.idx > count_pos)) begin
                res_status = ST_BADPOS;
              end else if (count_q == CW'(CAPACITY)) begin
                res_status = ST_FULL;
              end else begin
                cell_op = CELL_INS;
                count_d = count_q + 1'b1;
              end
            end
            OP_DEL: begin
              case (q_op_i.loc)
                LOC_FRONT: eidx = '0;
                LOC_BACK:  eidx = last_pos;
                default:   eidx = q_op_i.idx;
              endcase
              if (count_q == '0) begin
                res_status = ST_EMPTY;
              end else if (q_op_i.loc == LOC_POS &&
                           (q_op_i.pos_zero || q_op_i.idx >= count_pos)) begin
                res_status = ST_BADPOS;
              end else begin
                cell_op = CELL_DEL;
                count_d = count_q - 1'b1;
              end
            end
            OP_DUMP: begin
              if (count_q == '0) begin
                res_status = ST_EMPTY;
              end else begin
                // front cell goes out, the list rotates so the next one follows
                res_item = cells_q[0];
                res_last = (count_q == CW'(1));
                cell_op  = CELL_ROT;
                if (count_q != CW'(1)) begin
                  rem_d   = count_q - 1'b1;
                  state_d = S_DUMP;
                end
              end
            end
            default: begin
              res_status = ST_OK;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_ready) begin
          out_load = 1'b1;
          res_item = cells_q[0];
          res_last = (rem_q == CW'(1));
          cell_op  = CELL_ROT;
          rem_d    = rem_q - 1'b1;
          if (rem_q == CW'(1)) begin
            state_d = S_OP;
          end
        end
      end
      default: begin
        state_d = S_OP;
      end
    endcase
  end

  // cell array: a cell keeps itself, takes a neighbour, the new value or cell 0
  always_comb begin
    cells_d = cells_q;
    case (cell_op)
      CELL_INS: begin
        if (eidx == '0) begin
          cells_d[0] = q_op_i.value;
        end
        for (int i = 1; i < CAPACITY; i++) begin
          if (POS_W'(i) == eidx) begin
            cells_d[i] = q_op_i.value;
          end else if (POS_W'(i) > eidx) begin
            cells_d[i] = cells_q[i-1];
          end
        end
      end
      CELL_DEL: begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (POS_W'(i) >= eidx) begin
            cells_d[i] = cells_q[i+1];
          end
        end
      end
      CELL_ROT: begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if (POS_W'(i + 1) < count_pos) begin
            cells_d[i] = cells_q[i+1];
          end
        end
        for (int i = 0; i < CAPACITY; i++) begin
          if (POS_W'(i) == last_pos) begin
            cells_d[i] = cells_q[0];
          end
        end
      end
      default: begin
        cells_d = cells_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_OP;
      count_q     <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rem_q       <= rem_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    if (out_load) begin
      status_q <= res_status;
      length_q <= LEN_W'(count_d);
      item_q   <= res_item;
      last_q   <= res_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign length_o    = length_q;
  assign item_out_o  = item_q;
  assign is_last_o   = last_q;

endmodule

>>> design/positional_list_engine.sv
// ---------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed 32-bit values with positional insert, delete, dump
// ---------------------------------------------------------------------------
// Holds up to CAPACITY values in a row of shifting cells, front at cell 0.
// Input transactions are decoded and queued (two entries) ahead of the
// cell array, so input and output stall independently. Every insert or
// delete is carried out in the cell array and yields one result with a
// status and the new length; unused mode 7 likewise. A dump yields one
// result per stored value, read from the single front cell as the array
// rotates (or one result with status empty for an empty list); no further
// operation starts until the dump ends. An accepted transaction passes
// through a queue slot and then the output register before its result shows.
module positional_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ple_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [ple_pkg::ITEM_W-1:0] item_in_i,
  input  logic [ple_pkg::POS_W-1:0]         position_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ple_pkg::status_e                  status_o,
  output logic [ple_pkg::LEN_W-1:0]         length_o,
  output logic signed [ple_pkg::ITEM_W-1:0] item_out_o,
  output logic                              is_last_o
);
  import ple_pkg::*;

  op_t  front_op;
  op_t  queue_op;
  logic queue_full;
  logic queue_valid;
  logic queue_pop;

  assign in_stall_o = queue_full;

  ple_front u_front (
    .mode_i     (mode_i),
    .item_in_i  (item_in_i),
    .position_i (position_i),
    .op_o       (front_op)
  );

  ple_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .op_i    (front_op),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .op_o    (queue_op)
  );

  ple_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (queue_valid),
    .q_op_i      (queue_op),
    .q_pop_o     (queue_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .length_o    (length_o),
    .item_out_o  (item_out_o),
    .is_last_o   (is_last_o)
  );

endmodule

>>> design/ple_checker.sv
// ---------------------------------------------------------------------------
// ple_checker
// port-level checks on the result channel of the positional list engine
// ---------------------------------------------------------------------------
`include "positional_list_engine_defines.svh"

module ple_checker #(
  parameter int CAPACITY = 32
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input ple_pkg::status_e                  status_o,
  input logic [ple_pkg::LEN_W-1:0]         length_o,
  input logic signed [ple_pkg::ITEM_W-1:0] item_out_o,
  input logic                              is_last_o
);
  import ple_pkg::*;

  `PLE_ASSERT_NEXT(a_out_valid_hold, out_valid_o && out_stall_i, out_valid_o, "result dropped while stalled")
  `PLE_ASSERT_NEXT(a_out_payload_hold, out_valid_o && out_stall_i, $stable(item_out_o) && $stable(status_o) && $stable(length_o) && $stable(is_last_o), "result changed while stalled")
  `PLE_ASSERT_IMPLIES(a_full_length, out_valid_o && status_o == ST_FULL, length_o == LEN_W'(CAPACITY), "full status without full length")
  `PLE_ASSERT_IMPLIES(a_empty_result, out_valid_o && status_o == ST_EMPTY, length_o == '0 && is_last_o, "empty status on a non-empty or non-final result")
  `PLE_ASSERT_IMPLIES(a_item_only_ok, out_valid_o && status_o != ST_OK, item_out_o == '0, "value shown on a flagged result")

endmodule

bind positional_list_engine ple_checker #(.CAPACITY(CAPACITY)) u_ple_checker (.*);

>>> bench/tb_positional_list_engine.sv
// ---------------------------------------------------------------------------
// tb_positional_list_engine
// self-checking bench for the positional list engine
// ---------------------------------------------------------------------------
// A short table of directed transactions covers the empty list, the value
// extremes, every mode and the invalid-position cases. Random phases follow.
// They grow the list to full, mix operations, drain it to empty and mix
// again. A shadow list in the bench works out the replies of every accepted
// transaction. Each reply is checked field by field in arrival order. The
// sender idles in random bursts and the receiver stalls on its own pattern.
// ---------------------------------------------------------------------------
module tb_positional_list_engine;
  import ple_pkg::*;

  localparam int CAP = 32;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;
  // a no-transaction stretch is a sender gap plus a stall run plus the
  // pass through queue and output register, so this limit is many times over
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    status_e             status;
    logic [LEN_W-1:0]    length;
    logic signed [31:0]  item;
    logic                last;
  } reply_t;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic signed [31:0]  value;
    logic [POS_W-1:0]    pos;
    bit                  typed;
    status_e             status;
    logic [LEN_W-1:0]    length;
  } dir_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [MODE_W-1:0]         mode_i = '0;
  logic signed [ITEM_W-1:0]  item_in_i = '0;
  logic [POS_W-1:0]          position_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  status_e                   status_o;
  logic [LEN_W-1:0]          length_o;
  logic signed [ITEM_W-1:0]  item_out_o;
  logic                      is_last_o;

  // typed reply riding along with the driven transaction
  bit                        drv_typed = 1'b0;
  status_e                   drv_status = ST_OK;
  logic [LEN_W-1:0]          drv_length = '0;

  logic signed [31:0]        shadow_vals [CAP];
  int                        shadow_len = 0;
  reply_t                    op_replies [$];
  reply_t                    list_replies [$];

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int max_len_seen = 0;
  int status_seen [4] = '{0, 0, 0, 0};
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_style = 0;
  int stall_tick = 0;

  dir_row_t dir_rows [20];

  positional_list_engine #(.CAPACITY(CAP)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .mode_i     (mode_i),
    .item_in_i  (item_in_i),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .length_o   (length_o),
    .item_out_o (item_out_o),
    .is_last_o  (is_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic status_e list_insert(input int idx, input logic signed [31:0] v);
    int i;
    if (shadow_len >= CAP) return ST_FULL;
    for (i = shadow_len; i > idx; i--) shadow_vals[i] = shadow_vals[i-1];
    shadow_vals[idx] = v;
    shadow_len++;
    return ST_OK;
  endfunction

  function automatic status_e list_remove(input int idx);
    int i;
    if (shadow_len == 0) return ST_EMPTY;
    for (i = idx; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
    shadow_len--;
    return ST_OK;
  endfunction

  // updates the shadow list and leaves the replies in op_replies
  function automatic void apply_list_op(input logic [MODE_W-1:0] m,
                                        input logic signed [31:0] v,
                                        input logic [POS_W-1:0] p);
    status_e st;
    int      pi;
    int      i;
    st = ST_OK;
    pi = int'(p);
    op_replies.delete();
    case (m)
      MODE_INS_FRONT: st = list_insert(0, v);
      MODE_INS_BACK:  st = list_insert(shadow_len, v);
      MODE_INS_POS: begin
        if (pi < 1 || pi > shadow_len + 1) st = ST_BADPOS;
        else st = list_insert(pi - 1, v);
      end
      MODE_DEL_FRONT: st = list_remove(0);
      MODE_DEL_BACK:  st = list_remove(shadow_len - 1);
      MODE_DEL_POS: begin
        if (shadow_len == 0) st = ST_EMPTY;
        else if (pi < 1 || pi > shadow_len) st = ST_BADPOS;
        else st = list_remove(pi - 1);
      end
      MODE_DUMP: begin
        if (shadow_len == 0) begin
          op_replies.push_back('{ST_EMPTY, '0, '0, 1'b1});
        end else begin
          for (i = 0; i < shadow_len; i++)
            op_replies.push_back('{ST_OK, LEN_W'(shadow_len), shadow_vals[i],
                                   (i + 1 == shadow_len)});
        end
        return;
      end
      default: st = ST_OK;
    endcase
    op_replies.push_back('{st, LEN_W'(shadow_len), '0, 1'b1});
  endfunction

  task automatic flag(input string what);
    errors++;
    if (errors <= 10) $display("mismatch: %s", what);
  endtask

  // input transactions are folded into the shadow list before any reply
  // accepted at the same edge is checked
  always @(posedge clk_i) begin
    reply_t r;
    bit     moved;
    moved = 1'b0;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      moved = 1'b1;
      n_in++;
      apply_list_op(mode_i, item_in_i, position_i);
      if (shadow_len > max_len_seen) max_len_seen = shadow_len;
      if (drv_typed) list_replies.push_back('{drv_status, drv_length, '0, 1'b1});
      else foreach (op_replies[k]) list_replies.push_back(op_replies[k]);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      moved = 1'b1;
      n_out++;
      status_seen[status_o]++;
      if (list_replies.size() == 0) begin
        flag($sformatf("reply %0d with nothing awaited: status %0d len %0d item %0d last %0d",
                       n_out, status_o, length_o, item_out_o, is_last_o));
      end else begin
        r = list_replies.pop_front();
        if (status_o !== r.status || length_o !== r.length ||
            item_out_o !== r.item || is_last_o !== r.last)
          flag($sformatf({"reply %0d: exp status %0d len %0d item %0d last %0d, ",
                          "got status %0d len %0d item %0d last %0d"},
                         n_out, r.status, r.length, r.item, r.last,
                         status_o, length_o, item_out_o, is_last_o));
      end
    end
    if (moved) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // receiver stall pattern: none, random, long runs or alternate cycles
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_left == 0) begin
      stall_style = $urandom_range(3);
      stall_left = $urandom_range(20, 60);
    end else begin
      stall_left--;
    end
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(2) == 0);
      2:       out_stall_i <= ((stall_tick % 12) < 7);
      default: out_stall_i <= stall_tick[0];
    endcase
  end

  task automatic send_item(input logic [MODE_W-1:0] m, input logic signed [31:0] v,
                           input logic [POS_W-1:0] p, input bit typed,
                           input status_e st, input logic [LEN_W-1:0] len);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= m;
    item_in_i <= v;
    position_i <= p;
    drv_typed <= typed;
    drv_status <= st;
    drv_length <= len;
    burst_left--;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // sender holds off until every awaited reply has arrived
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (list_replies.size() != 0) @(posedge clk_i);
  endtask

  // runs until the list length hits target (then extra more), or cap items
  task automatic random_phase(input int grow_pct, input int target, input int extra,
                              input int cap);
    logic [MODE_W-1:0]  m;
    logic signed [31:0] v;
    logic [POS_W-1:0]   p;
    int r;
    int lim;
    int n;
    int after;
    bit hit;
    hit = 1'b0;
    after = 0;
    for (n = 0; n < cap && !(hit && after >= extra); n++) begin
      r = $urandom_range(99);
      if (r < grow_pct) m = 3'($urandom_range(MODE_INS_FRONT, MODE_INS_POS));
      else if (r < 94) m = 3'($urandom_range(MODE_DEL_FRONT, MODE_DEL_POS));
      else if (r < 98) m = MODE_DUMP;
      else m = MODE_UNUSED;
      lim = (m == MODE_INS_POS) ? shadow_len + 1 : shadow_len;
      r = $urandom_range(9);
      if (r < 7) p = 8'($urandom_range(1, (lim > 1) ? lim : 1));
      else if (r == 7) p = '0;
      else if (r == 8) p = 8'(lim + 1);
      else p = 8'($urandom_range(255));
      r = $urandom_range(7);
      if (r == 0) v = 32'sh7fffffff;
      else if (r == 1) v = 32'sh80000000;
      else v = $urandom;
      send_item(m, v, p, 1'b0, ST_OK, '0);
      if (hit) after++;
      if (shadow_len == target) hit = 1'b1;
    end
  endtask

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    dir_rows = '{
      '{MODE_DUMP,      32'sd0,          8'd0,   1'b1, ST_EMPTY,  6'd0},
      '{MODE_DEL_FRONT, 32'sd0,          8'd0,   1'b1, ST_EMPTY,  6'd0},
      '{MODE_DEL_BACK,  32'sd0,          8'd0,   1'b1, ST_EMPTY,  6'd0},
      '{MODE_DEL_POS,   32'sd0,          8'd5,   1'b1, ST_EMPTY,  6'd0},
      '{MODE_INS_POS,   32'sd7,          8'd0,   1'b1, ST_BADPOS, 6'd0},
      '{MODE_INS_POS,   32'sd7,          8'd2,   1'b1, ST_BADPOS, 6'd0},
      '{MODE_INS_FRONT, 32'sh7fffffff,   8'd0,   1'b1, ST_OK,     6'd1},
      '{MODE_INS_BACK,  32'sh80000000,   8'd0,   1'b1, ST_OK,     6'd2},
      '{MODE_INS_POS,   -32'sd1,         8'd3,   1'b1, ST_OK,     6'd3},
      '{MODE_INS_POS,   32'sd9,          8'd255, 1'b1, ST_BADPOS, 6'd3},
      '{MODE_INS_POS,   32'sd0,          8'd1,   1'b1, ST_OK,     6'd4},
      '{MODE_INS_POS,   32'sh12345678,   8'd3,   1'b1, ST_OK,     6'd5},
      '{MODE_DUMP,      32'sd0,          8'd0,   1'b0, ST_OK,     6'd0},
      '{MODE_DEL_POS,   32'sd0,          8'd0,   1'b1, ST_BADPOS, 6'd5},
      '{MODE_DEL_POS,   32'sd0,          8'd6,   1'b1, ST_BADPOS, 6'd5},
      '{MODE_DEL_POS,   32'sd0,          8'd3,   1'b0, ST_OK,     6'd0},
      '{MODE_UNUSED,    32'sd0,          8'd0,   1'b1, ST_OK,     6'd4},
      '{MODE_DEL_FRONT, 32'sd0,          8'd0,   1'b0, ST_OK,     6'd0},
      '{MODE_DEL_BACK,  32'sd0,          8'd0,   1'b0, ST_OK,     6'd0},
      '{MODE_DUMP,      32'sd0,          8'd0,   1'b0, ST_OK,     6'd0}
    };
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].pos, dir_rows[i].typed,
                dir_rows[i].status, dir_rows[i].length);
    wait_drained();

    random_phase(90, CAP, 10, 90);
    wait_drained();
    random_phase(50, -1, 0, 20);
    random_phase(10, 0, 8, 90);
    wait_drained();
    random_phase(50, -1, 0, 15);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (list_replies.size() != 0)
      flag($sformatf("%0d replies never arrived", list_replies.size()));

    $display("covered %0d transactions in and %0d replies out, longest list %0d of %0d",
             n_in, n_out, max_len_seen, CAP);
    $display("status counts: ok %0d, bad position %0d, full %0d, empty %0d; mismatches %0d",
             status_seen[ST_OK], status_seen[ST_BADPOS], status_seen[ST_FULL],
             status_seen[ST_EMPTY], errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
